FILE: sv/tcw_pkg.sv
// tcw_pkg: types, constants and helper functions of the text console char writer
// no dependencies; imported by every module of the block but tcw_ram
`default_nettype none

package tcw_pkg;

  localparam int unsigned COLUMNS     = 80;
  localparam int unsigned ROWS        = 25;
  localparam int unsigned PAGE_CELLS  = 2048;
  localparam int unsigned STORE_CELLS = 16384;
  localparam int unsigned TAB_STOP    = 8;

  localparam int unsigned ADDR_W = $clog2(STORE_CELLS);
  localparam int unsigned CELL_W = 16;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned PAGE_W = 3;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned OFS_W  = $clog2(ROWS * COLUMNS);
  localparam int unsigned TAB_SH = $clog2(TAB_STOP);
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [CHAR_W-1:0] CH_BS      = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL      = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic REG_FILL = 1'b0;
  localparam logic REG_PAGE = 1'b1;

  localparam logic [ATTR_W-1:0] FILL_RESET = 8'd7;
  localparam logic [PAGE_W-1:0] PAGE_RESET = 3'd0;

  typedef struct packed {
    logic              opcode;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_index;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [ADDR_W-1:0] crtc_addr;
    logic              scrolled;
    logic [CELL_W-1:0] cell_data;
  } result_t;

  typedef struct packed {
    logic [ATTR_W-1:0] fill_attribute;
    logic [PAGE_W-1:0] disp_page;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] wdata;
  } ram_req_t;

  function automatic logic [ADDR_W-1:0] page_base(input logic [PAGE_W-1:0] page);
    return ADDR_W'(32'(page) * PAGE_CELLS);
  endfunction

endpackage

`default_nettype wire

FILE: sv/text_console_char_writer.sv
// text_console_char_writer: 80x25 text console with cursor, paged screen ram and scroll
// depends on tcw_pkg, tcw_ram, tcw_addr_unit, tcw_core
// sequence: a read, a printable byte or a backspace passes decode and the ram write-back
//   state before the result beat; a byte that wraps also passes the newline state, as do a
//   newline and a wrapping tab; a tab on the row or a backspace at the page origin goes
//   from decode to the result; a scroll copies each lower row up by a read and a write per
//   cell, then blanks the last row; a new item is taken only once the block is idle again
// reset: cursor to 0,0; the ram is cleared one cell a cycle over all STORE_CELLS (16384)
`default_nettype none

module text_console_char_writer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // command channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire tcw_pkg::item_t                item_i,
  // result channel, one-cycle strobe, no backpressure
  output logic                               result_valid_o,
  output tcw_pkg::result_t                   result_o,
  // apb configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tcw_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [tcw_pkg::PDATA_W-1:0]   pwdata,
  output logic      [tcw_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);
  import tcw_pkg::*;

  // configuration registers
  logic [ATTR_W-1:0] fill_q;
  logic [PAGE_W-1:0] page_q;
  logic              cfg_we;
  logic              reg_sel;
  cfg_t              cfg;

  // ram and address unit hookup
  ram_req_t          ram_req;
  logic [CELL_W-1:0] ram_rdata;
  logic [OFS_W-1:0]  au_offset;
  logic [ADDR_W-1:0] au_addr;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  // registers sit on 4-byte steps, so the word index is paddr[2]
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= FILL_RESET;
      page_q <= PAGE_RESET;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_FILL: fill_q <= pwdata[ATTR_W-1:0];
        REG_PAGE: page_q <= pwdata[PAGE_W-1:0];
        default:  fill_q <= fill_q;
      endcase
    end
  end

  // read mux, unused upper bits read as zero
  always_comb begin
    unique case (reg_sel)
      REG_FILL: prdata = PDATA_W'(fill_q);
      REG_PAGE: prdata = PDATA_W'(page_q);
      default:  prdata = '0;
    endcase
  end

  assign cfg.fill_attribute = fill_q;
  assign cfg.disp_page      = page_q;

  // sequencer: clear pass, item decode, read-modify-write, scroll walk
  tcw_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .item_i         (item_i),
    .cfg_i          (cfg),
    .busy_o         (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .ram_req_o      (ram_req),
    .ram_rdata_i    (ram_rdata),
    .au_offset_o    (au_offset),
    .au_addr_i      (au_addr)
  );

  // one adder shared by the cursor-relative and scroll cell addresses and the cursor word
  tcw_addr_unit u_addr (
    .page_i   (page_q),
    .offset_i (au_offset),
    .addr_o   (au_addr)
  );

  // screen store, all pages
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (STORE_CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

FILE: sv/tcw_ram.sv
// tcw_ram: generic single-port ram with registered read data
// no dependencies
`default_nettype none

module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/tcw_addr_unit.sv
// tcw_addr_unit: shared cell address adder, page base plus offset modulo the store
// depends on tcw_pkg
`default_nettype none

module tcw_addr_unit (
  input  wire logic [tcw_pkg::PAGE_W-1:0] page_i,
  input  wire logic [tcw_pkg::OFS_W-1:0]  offset_i,
  output logic      [tcw_pkg::ADDR_W-1:0] addr_o
);
  import tcw_pkg::*;

  // wraps modulo the store size by truncation
  assign addr_o = page_base(page_i) + ADDR_W'(offset_i);

endmodule

`default_nettype wire

FILE: sv/tcw_core.sv
// tcw_core: sequencer for put, read, tab, backspace, newline and scroll, plus the clear pass
// depends on tcw_pkg; drives the screen ram and the shared address unit
`default_nettype none

module tcw_core (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire tcw_pkg::item_t           item_i,
  input  wire tcw_pkg::cfg_t            cfg_i,
  output logic                          busy_o,
  output logic                          result_valid_o,
  output tcw_pkg::result_t              result_o,
  output tcw_pkg::ram_req_t             ram_req_o,
  input  wire logic [tcw_pkg::CELL_W-1:0] ram_rdata_i,
  output logic      [tcw_pkg::OFS_W-1:0]  au_offset_o,
  input  wire logic [tcw_pkg::ADDR_W-1:0] au_addr_i
);
  import tcw_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_DECODE = 9'b000000100,
    S_WB     = 9'b000001000,
    S_NEWLN  = 9'b000010000,
    S_SCR_RD = 9'b000100000,
    S_SCR_WR = 9'b001000000,
    S_BLANK  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  state_e              state_q, state_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    line_q, line_d;
  logic                scrolled_q, scrolled_d;
  logic [OFS_W-1:0]    cnt_q, cnt_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  item_t               item_q, item_d;
  logic [CELL_W-1:0]   data_q, data_d;

  logic [OFS_W-1:0]    lin;
  logic [COL_W-1:0]    tab_nx;
  logic [COL_W-1:0]    col_inc;

  assign lin     = OFS_W'(32'(line_q) * COLUMNS) + OFS_W'(col_q);
  assign tab_nx  = {col_q[COL_W-1:TAB_SH] + (COL_W-TAB_SH)'(1), TAB_SH'(0)};
  assign col_inc = col_q + COL_W'(1);

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    line_d      = line_q;
    scrolled_d  = scrolled_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    item_d      = item_q;
    data_d      = data_q;
    au_offset_o = lin;
    ram_req_o.we    = 1'b0;
    ram_req_o.addr  = au_addr_i;
    ram_req_o.wdata = '0;

    unique case (state_q)
      S_CLEAR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.addr  = clr_q;
        ram_req_o.wdata = '0;
        clr_d           = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(STORE_CELLS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          item_d     = item_i;
          scrolled_d = 1'b0;
          data_d     = '0;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (item_q.opcode == OP_READ) begin
          ram_req_o.addr = item_q.cell_index;
          state_d        = S_WB;
        end else begin
          case (item_q.char_code)
            CH_TAB: begin
              if (32'(tab_nx) >= COLUMNS) begin
                state_d = S_NEWLN;
              end else begin
                col_d   = tab_nx;
                state_d = S_DONE;
              end
            end
            CH_NL: begin
              state_d = S_NEWLN;
            end
            CH_BS: begin
              if (lin != '0) begin
                au_offset_o = lin - OFS_W'(1);
                state_d     = S_WB;
              end else begin
                state_d = S_DONE;
              end
            end
            default: begin
              state_d = S_WB;
            end
          endcase
        end
      end
      S_WB: begin
        if (item_q.opcode == OP_READ) begin
          data_d  = ram_rdata_i;
          state_d = S_DONE;
        end else if (item_q.char_code == CH_BS) begin
          au_offset_o     = lin - OFS_W'(1);
          ram_req_o.we    = 1'b1;
          ram_req_o.wdata = {ram_rdata_i[CELL_W-1:CHAR_W], BLANK_CHAR};
          state_d         = S_DONE;
        end else begin
          ram_req_o.we    = 1'b1;
          ram_req_o.wdata = {ram_rdata_i[CELL_W-1:CHAR_W], item_q.char_code};
          if (32'(col_inc) >= COLUMNS) begin
            state_d = S_NEWLN;
          end else begin
            col_d   = col_inc;
            state_d = S_DONE;
          end
        end
      end
      S_NEWLN: begin
        col_d = '0;
        if (line_q >= ROW_W'(ROWS - 1)) begin
          line_d     = ROW_W'(ROWS - 1);
          scrolled_d = 1'b1;
          cnt_d      = '0;
          state_d    = S_SCR_RD;
        end else begin
          line_d  = line_q + ROW_W'(1);
          state_d = S_DONE;
        end
      end
      S_SCR_RD: begin
        au_offset_o = cnt_q + OFS_W'(COLUMNS);
        state_d     = S_SCR_WR;
      end
      S_SCR_WR: begin
        au_offset_o     = cnt_q;
        ram_req_o.we    = 1'b1;
        ram_req_o.wdata = ram_rdata_i;
        cnt_d           = cnt_q + OFS_W'(1);
        if (cnt_q == OFS_W'((ROWS - 1) * COLUMNS - 1)) begin
          state_d = S_BLANK;
        end else begin
          state_d = S_SCR_RD;
        end
      end
      S_BLANK: begin
        au_offset_o     = cnt_q;
        ram_req_o.we    = 1'b1;
        ram_req_o.wdata = {cfg_i.fill_attribute, BLANK_CHAR};
        cnt_d           = cnt_q + OFS_W'(1);
        if (cnt_q == OFS_W'(ROWS * COLUMNS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      col_q      <= '0;
      line_q     <= '0;
      scrolled_q <= 1'b0;
      cnt_q      <= '0;
      clr_q      <= '0;
    end else begin
      state_q    <= state_d;
      col_q      <= col_d;
      line_q     <= line_d;
      scrolled_q <= scrolled_d;
      cnt_q      <= cnt_d;
      clr_q      <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    data_q <= data_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_DONE);

  always_comb begin
    result_o.cursor_column = col_q;
    result_o.cursor_row    = line_q;
    result_o.crtc_addr     = au_addr_i;
    result_o.scrolled      = scrolled_q;
    result_o.cell_data     = data_q;
  end

endmodule

`default_nettype wire

FILE: sv/tcw_checker.sv
// tcw_checker: port-level assertions for text_console_char_writer, bound to the top level
// depends on tcw_pkg and text_console_char_writer
`default_nettype none

module tcw_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             result_valid_o,
  input wire tcw_pkg::result_t result_o,
  input wire logic             pready
);
  import tcw_pkg::*;

  // an accepted beat keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accept did not raise busy");

  // a result only appears while an item is in flight
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe while idle");

  // exactly one strobe per item, and the block frees up right after
  a_strobe_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o && !busy)
    else $error("result strobe longer than one cycle");

  // reported cursor stays on screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (32'(result_o.cursor_column) < COLUMNS) &&
                       (32'(result_o.cursor_row) < ROWS))
    else $error("cursor off screen");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind text_console_char_writer tcw_checker u_tcw_checker (.*);

`default_nettype wire
